>>> design/assert_macros.svh
// ------------------------------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the tree engine.
// ------------------------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BST_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tree engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tree engine check failed");

// Expression must never be true.
`define BST_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tree engine check failed");

`endif

>>> design/bst_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------------
// Tree engine package
// Operation and status codes, default sizes and the memory write-enable group.
// ------------------------------------------------------------------------------------------------
package bst_pkg;

   localparam int NODE_COUNT_DEFAULT = 1024;
   localparam int KEY_BITS_DEFAULT   = 32;

   localparam int FUNC_BITS   = 3;
   localparam int STATUS_BITS = 2;

   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_DELETE = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_SEARCH = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_CEIL   = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_LOWER  = 3'd5;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

   // One write strobe for each array of the node memory.
   typedef struct packed {
      logic key;
      logic left;
      logic right;
      logic parent;
   } mem_we_type;

endpackage

>>> design/bst_if.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------------
// Tree engine channels
// Request and response channels with a valid/ready handshake.
// ------------------------------------------------------------------------------------------------
interface bst_req_if #(
   parameter int KEY_BITS = bst_pkg::KEY_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic [bst_pkg::FUNC_BITS-1:0]     func;
   logic signed [KEY_BITS-1:0]        key;

   modport source (output valid, output func, output key, input ready);
   modport sink   (input valid, input func, input key, output ready);
endinterface

interface bst_rsp_if #(
   parameter int KEY_BITS  = bst_pkg::KEY_BITS_DEFAULT,
   parameter int SLOT_BITS = $clog2(bst_pkg::NODE_COUNT_DEFAULT)
);
   logic                              valid;
   logic                              ready;
   logic [bst_pkg::STATUS_BITS-1:0]   status;
   logic signed [KEY_BITS-1:0]        found_key;
   logic [SLOT_BITS-1:0]              node_slot;
   logic [SLOT_BITS:0]                entries;

   modport source (output valid, output status, output found_key, output node_slot,
                   output entries, input ready);
   modport sink   (input valid, input status, input found_key, input node_slot,
                   input entries, output ready);
endinterface

>>> design/binary_search_tree_engine.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------------
// Binary search tree engine
// Unbalanced search tree in a node memory with clear, insert, delete and bound queries.
// ------------------------------------------------------------------------------------------------
// The engine takes one request beat at a time and answers each with exactly one response beat;
// it is not ready for the next request until the response has been taken. Clear, a full pool and
// an unused operation code go straight to the response state. Insert, search, ceiling and strict
// lower walk from the root with one read of the node memory per level. Delete walks to the key,
// then follows the chain of replacement nodes (in-order successor, or predecessor where there is
// no right child) one read per step, and finally relinks every node of that chain through the
// pop, fetch, link and two fix states, innermost first. All steps share the single read port of
// the node memory and the one key comparator.
// Nodes are handed out in order and never reused, even after clear; insert reports a full pool
// once all of them have been issued. No clearing pass is needed after reset.
// ------------------------------------------------------------------------------------------------
module binary_search_tree_engine #(
   parameter int NODE_COUNT = bst_pkg::NODE_COUNT_DEFAULT,
   parameter int KEY_BITS   = bst_pkg::KEY_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bst_req_if.sink    req_chan,
   bst_rsp_if.source  rsp_chan
);

   localparam int SLOT_BITS = $clog2(NODE_COUNT);
   localparam int IDX_BITS  = SLOT_BITS + 1;
   // Link value that marks an absent node.
   localparam logic [IDX_BITS-1:0] NIL = IDX_BITS'(NODE_COUNT);

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WALK  = 4'd1;
   localparam logic [3:0] S_CHAIN = 4'd2;
   localparam logic [3:0] S_POP   = 4'd3;
   localparam logic [3:0] S_FETCH = 4'd4;
   localparam logic [3:0] S_LINK  = 4'd5;
   localparam logic [3:0] S_FIX1  = 4'd6;
   localparam logic [3:0] S_FIX2  = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   function automatic logic is_node(input logic [IDX_BITS-1:0] idx);
      return idx < NIL;
   endfunction

   // Control state.
   logic [3:0]                         state_ff, state_in;
   logic [IDX_BITS-1:0]                root_ff, root_in;
   logic [IDX_BITS-1:0]                count_ff, count_in;
   logic [IDX_BITS-1:0]                next_ff, next_in;
   logic [IDX_BITS-1:0]                sp_ff, sp_in;

   // Working registers of the current operation.
   logic [bst_pkg::FUNC_BITS-1:0]      func_ff, func_in;
   logic signed [KEY_BITS-1:0]         key_ff, key_in;
   logic [IDX_BITS-1:0]                cur_ff, cur_in;
   logic [IDX_BITS-1:0]                cand_ff, cand_in;
   logic                               dir_ff, dir_in;
   logic [IDX_BITS-1:0]                id_ff, id_in;
   logic [IDX_BITS-1:0]                rep_ff, rep_in;
   logic [IDX_BITS-1:0]                lk_left_ff, lk_left_in;
   logic [IDX_BITS-1:0]                lk_right_ff, lk_right_in;
   logic [IDX_BITS-1:0]                lk_par_ff, lk_par_in;

   // Result held for the response beat.
   logic [IDX_BITS-1:0]                slot_ff, slot_in;
   logic signed [KEY_BITS-1:0]         rkey_ff, rkey_in;
   logic [bst_pkg::STATUS_BITS-1:0]    status_ff, status_in;

   // Node memory ports.
   logic [SLOT_BITS-1:0]               mem_rd_addr;
   bst_pkg::mem_we_type                mem_we;
   logic [SLOT_BITS-1:0]               key_wa, left_wa, right_wa, parent_wa;
   logic signed [KEY_BITS-1:0]         key_wd;
   logic [IDX_BITS-1:0]                left_wd, right_wd, parent_wd;
   logic signed [KEY_BITS-1:0]         rd_key;
   logic [IDX_BITS-1:0]                rd_left, rd_right, rd_parent;

   // Replacement chain stack, written during the chain walk and read back during relinking.
   logic [SLOT_BITS-1:0]               stk_mem [NODE_COUNT];
   logic                               stk_we;
   logic [SLOT_BITS-1:0]               stk_wa, stk_ra, stk_wd, stk_q;
   logic [IDX_BITS-1:0]                sp_dec;

   // The shared key comparator: request key against the node key just read.
   logic                               key_lt, key_eq;
   logic [IDX_BITS-1:0]                nxt;
   logic                               take;
   logic                               do_start;
   logic [IDX_BITS-1:0]                chain_x;

   bst_node_mem #(
      .NODE_COUNT (NODE_COUNT),
      .KEY_BITS   (KEY_BITS)
   ) u_mem (
      .clock     (clock),
      .rd_addr   (mem_rd_addr),
      .we        (mem_we),
      .key_wa    (key_wa),
      .key_wd    (key_wd),
      .left_wa   (left_wa),
      .left_wd   (left_wd),
      .right_wa  (right_wa),
      .right_wd  (right_wd),
      .parent_wa (parent_wa),
      .parent_wd (parent_wd),
      .rd_key    (rd_key),
      .rd_left   (rd_left),
      .rd_right  (rd_right),
      .rd_parent (rd_parent)
   );

   assign key_lt  = key_ff < rd_key;
   assign key_eq  = key_ff == rd_key;
   assign sp_dec  = sp_ff - IDX_BITS'(1);
   assign chain_x = (state_ff == S_WALK) ? cur_ff : cand_ff;

   always_comb begin
      state_in    = state_ff;
      root_in     = root_ff;
      count_in    = count_ff;
      next_in     = next_ff;
      sp_in       = sp_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      cur_in      = cur_ff;
      cand_in     = cand_ff;
      dir_in      = dir_ff;
      id_in       = id_ff;
      rep_in      = rep_ff;
      lk_left_in  = lk_left_ff;
      lk_right_in = lk_right_ff;
      lk_par_in   = lk_par_ff;
      slot_in     = slot_ff;
      rkey_in     = rkey_ff;
      status_in   = status_ff;

      mem_rd_addr = cur_ff[SLOT_BITS-1:0];
      mem_we      = '0;
      key_wa      = next_ff[SLOT_BITS-1:0];
      key_wd      = req_chan.key;
      left_wa     = next_ff[SLOT_BITS-1:0];
      left_wd     = NIL;
      right_wa    = next_ff[SLOT_BITS-1:0];
      right_wd    = NIL;
      parent_wa   = next_ff[SLOT_BITS-1:0];
      parent_wd   = NIL;

      stk_we      = 1'b0;
      stk_wa      = sp_ff[SLOT_BITS-1:0];
      stk_wd      = chain_x[SLOT_BITS-1:0];
      stk_ra      = sp_dec[SLOT_BITS-1:0];

      nxt         = key_lt ? rd_left : rd_right;
      take        = 1'b0;
      do_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in     = req_chan.func;
               key_in      = req_chan.key;
               slot_in     = NIL;
               status_in   = bst_pkg::STATUS_OK;
               cur_in      = root_ff;
               mem_rd_addr = root_ff[SLOT_BITS-1:0];
               state_in    = S_RESP;
               case (req_chan.func)
                  bst_pkg::FUNC_CLEAR: begin
                     root_in  = NIL;
                     count_in = '0;
                  end
                  bst_pkg::FUNC_INSERT: begin
                     if (!is_node(next_ff)) begin
                        status_in = bst_pkg::STATUS_FULL;
                     end else begin
                        // The new node is written whole before the walk starts.
                        slot_in = next_ff;
                        rkey_in = req_chan.key;
                        mem_we  = '{key: 1'b1, left: 1'b1, right: 1'b1, parent: 1'b1};
                        if (!is_node(root_ff)) begin
                           root_in  = next_ff;
                           next_in  = next_ff + IDX_BITS'(1);
                           count_in = count_ff + IDX_BITS'(1);
                        end else begin
                           state_in = S_WALK;
                        end
                     end
                  end
                  bst_pkg::FUNC_DELETE, bst_pkg::FUNC_SEARCH,
                  bst_pkg::FUNC_CEIL, bst_pkg::FUNC_LOWER: begin
                     if (is_node(root_ff)) begin
                        state_in = S_WALK;
                     end else begin
                        status_in = bst_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_WALK: begin
            case (func_ff)
               bst_pkg::FUNC_INSERT: begin
                  if (is_node(nxt)) begin
                     cur_in      = nxt;
                     mem_rd_addr = nxt[SLOT_BITS-1:0];
                  end else begin
                     if (key_lt) begin
                        mem_we.left = 1'b1;
                        left_wa     = cur_ff[SLOT_BITS-1:0];
                        left_wd     = slot_ff;
                     end else begin
                        mem_we.right = 1'b1;
                        right_wa     = cur_ff[SLOT_BITS-1:0];
                        right_wd     = slot_ff;
                     end
                     mem_we.parent = 1'b1;
                     parent_wa     = slot_ff[SLOT_BITS-1:0];
                     parent_wd     = cur_ff;
                     next_in       = next_ff + IDX_BITS'(1);
                     count_in      = count_ff + IDX_BITS'(1);
                     state_in      = S_RESP;
                  end
               end
               bst_pkg::FUNC_SEARCH, bst_pkg::FUNC_DELETE: begin
                  if (key_eq) begin
                     slot_in = cur_ff;
                     rkey_in = rd_key;
                     if (func_ff == bst_pkg::FUNC_SEARCH) begin
                        state_in = S_RESP;
                     end else begin
                        do_start = 1'b1;
                     end
                  end else if (is_node(nxt)) begin
                     cur_in      = nxt;
                     mem_rd_addr = nxt[SLOT_BITS-1:0];
                  end else begin
                     status_in = bst_pkg::STATUS_NOT_FOUND;
                     state_in  = S_RESP;
                  end
               end
               bst_pkg::FUNC_CEIL, bst_pkg::FUNC_LOWER: begin
                  // Ceiling keeps nodes at or above the key, lower keeps nodes strictly below.
                  if (func_ff == bst_pkg::FUNC_CEIL) begin
                     take = key_lt || key_eq;
                     nxt  = take ? rd_left : rd_right;
                  end else begin
                     take = !(key_lt || key_eq);
                     nxt  = take ? rd_right : rd_left;
                  end
                  if (take) begin
                     slot_in = cur_ff;
                     rkey_in = rd_key;
                  end
                  if (is_node(nxt)) begin
                     cur_in      = nxt;
                     mem_rd_addr = nxt[SLOT_BITS-1:0];
                  end else begin
                     status_in = (take || is_node(slot_ff)) ? bst_pkg::STATUS_OK
                                                              : bst_pkg::STATUS_NOT_FOUND;
                     state_in  = S_RESP;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_CHAIN: begin
            nxt = dir_ff ? rd_right : rd_left;
            if (is_node(nxt)) begin
               cand_in     = nxt;
               mem_rd_addr = nxt[SLOT_BITS-1:0];
            end else begin
               do_start = 1'b1;
            end
         end

         S_POP: begin
            sp_in    = sp_dec;
            state_in = S_FETCH;
         end

         S_FETCH: begin
            id_in       = {1'b0, stk_q};
            mem_rd_addr = stk_q;
            state_in    = S_LINK;
         end

         S_LINK: begin
            // The replacement takes over the links of the node it stands in for.
            lk_left_in  = rd_left;
            lk_right_in = rd_right;
            lk_par_in   = rd_parent;
            if (is_node(rep_ff)) begin
               mem_we.left   = 1'b1;
               mem_we.right  = 1'b1;
               mem_we.parent = 1'b1;
               left_wa       = rep_ff[SLOT_BITS-1:0];
               right_wa      = rep_ff[SLOT_BITS-1:0];
               parent_wa     = rep_ff[SLOT_BITS-1:0];
               left_wd       = rd_left;
               right_wd      = rd_right;
               parent_wd     = rd_parent;
            end
            mem_rd_addr = rd_parent[SLOT_BITS-1:0];
            state_in    = S_FIX1;
         end

         S_FIX1: begin
            if (is_node(rep_ff) && is_node(lk_left_ff)) begin
               mem_we.parent = 1'b1;
               parent_wa     = lk_left_ff[SLOT_BITS-1:0];
               parent_wd     = rep_ff;
            end
            // The parent side is picked by which child link holds the node.
            if (id_ff == root_ff) begin
               root_in = rep_ff;
            end else if (is_node(lk_par_ff)) begin
               if (rd_left == id_ff) begin
                  mem_we.left = 1'b1;
                  left_wa     = lk_par_ff[SLOT_BITS-1:0];
                  left_wd     = rep_ff;
               end else begin
                  mem_we.right = 1'b1;
                  right_wa     = lk_par_ff[SLOT_BITS-1:0];
                  right_wd     = rep_ff;
               end
            end
            state_in = S_FIX2;
         end

         S_FIX2: begin
            if (is_node(rep_ff) && is_node(lk_right_ff)) begin
               mem_we.parent = 1'b1;
               parent_wa     = lk_right_ff[SLOT_BITS-1:0];
               parent_wd     = rep_ff;
            end
            rep_in = id_ff;
            if (sp_ff == '0) begin
               if (count_ff != '0) begin
                  count_in = count_ff - IDX_BITS'(1);
               end
               state_in = S_RESP;
            end else begin
               state_in = S_POP;
            end
         end

         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Push a chain node and look for its own replacement from the links just read.
      if (do_start) begin
         stk_we = 1'b1;
         sp_in  = sp_ff + IDX_BITS'(1);
         if (is_node(rd_right)) begin
            cand_in     = rd_right;
            dir_in      = 1'b0;
            mem_rd_addr = rd_right[SLOT_BITS-1:0];
            state_in    = S_CHAIN;
         end else if (is_node(rd_left)) begin
            cand_in     = rd_left;
            dir_in      = 1'b1;
            mem_rd_addr = rd_left[SLOT_BITS-1:0];
            state_in    = S_CHAIN;
         end else begin
            rep_in   = NIL;
            state_in = S_POP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         root_ff  <= NIL;
         count_ff <= '0;
         next_ff  <= '0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         root_ff  <= root_in;
         count_ff <= count_in;
         next_ff  <= next_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      cur_ff      <= cur_in;
      cand_ff     <= cand_in;
      dir_ff      <= dir_in;
      id_ff       <= id_in;
      rep_ff      <= rep_in;
      lk_left_ff  <= lk_left_in;
      lk_right_ff <= lk_right_in;
      lk_par_ff   <= lk_par_in;
      slot_ff     <= slot_in;
      rkey_ff     <= rkey_in;
      status_ff   <= status_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_q <= stk_mem[stk_ra];
   end

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = (state_ff == S_RESP);
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.found_key = is_node(slot_ff) ? rkey_ff : '0;
   assign rsp_chan.node_slot = is_node(slot_ff) ? slot_ff[SLOT_BITS-1:0] : '0;
   assign rsp_chan.entries   = count_ff;

endmodule

>>> design/bst_node_mem.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------------
// Tree node memory
// Key, left, right and parent arrays; one write port each and a shared registered read.
// ------------------------------------------------------------------------------------------------
module bst_node_mem #(
   parameter int NODE_COUNT = bst_pkg::NODE_COUNT_DEFAULT,
   parameter int KEY_BITS   = bst_pkg::KEY_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic [$clog2(NODE_COUNT)-1:0]          rd_addr,
   input  bst_pkg::mem_we_type                    we,
   input  logic [$clog2(NODE_COUNT)-1:0]          key_wa,
   input  logic signed [KEY_BITS-1:0]             key_wd,
   input  logic [$clog2(NODE_COUNT)-1:0]          left_wa,
   input  logic [$clog2(NODE_COUNT):0]            left_wd,
   input  logic [$clog2(NODE_COUNT)-1:0]          right_wa,
   input  logic [$clog2(NODE_COUNT):0]            right_wd,
   input  logic [$clog2(NODE_COUNT)-1:0]          parent_wa,
   input  logic [$clog2(NODE_COUNT):0]            parent_wd,
   output logic signed [KEY_BITS-1:0]             rd_key,
   output logic [$clog2(NODE_COUNT):0]            rd_left,
   output logic [$clog2(NODE_COUNT):0]            rd_right,
   output logic [$clog2(NODE_COUNT):0]            rd_parent
);

   localparam int SLOT_BITS = $clog2(NODE_COUNT);
   localparam int IDX_BITS  = SLOT_BITS + 1;

   logic signed [KEY_BITS-1:0] key_mem    [NODE_COUNT];
   logic [IDX_BITS-1:0]        left_mem   [NODE_COUNT];
   logic [IDX_BITS-1:0]        right_mem  [NODE_COUNT];
   logic [IDX_BITS-1:0]        parent_mem [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (we.key) begin
         key_mem[key_wa] <= key_wd;
      end
      if (we.left) begin
         left_mem[left_wa] <= left_wd;
      end
      if (we.right) begin
         right_mem[right_wa] <= right_wd;
      end
      if (we.parent) begin
         parent_mem[parent_wa] <= parent_wd;
      end
      rd_key    <= key_mem[rd_addr];
      rd_left   <= left_mem[rd_addr];
      rd_right  <= right_mem[rd_addr];
      rd_parent <= parent_mem[rd_addr];
   end

endmodule

>>> design/bst_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------------
// Tree engine checker
// Port-level checks on the tree engine, attached to it by a bind.
// ------------------------------------------------------------------------------------------------
`include "assert_macros.svh"

module bst_checker #(
   parameter int KEY_BITS  = bst_pkg::KEY_BITS_DEFAULT,
   parameter int SLOT_BITS = $clog2(bst_pkg::NODE_COUNT_DEFAULT)
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [bst_pkg::FUNC_BITS-1:0]     req_func,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [bst_pkg::STATUS_BITS-1:0]   rsp_status,
   input logic [KEY_BITS-1:0]               rsp_found_key,
   input logic [SLOT_BITS-1:0]              rsp_node_slot,
   input logic [SLOT_BITS:0]                rsp_entries
);

   logic clear_taken;
   logic clear_answer;
   logic miss_beat;
   logic miss_clean;

   assign clear_taken  = req_valid && req_ready && (req_func == bst_pkg::FUNC_CLEAR);
   assign clear_answer = rsp_valid && (rsp_entries == '0) && (rsp_status == bst_pkg::STATUS_OK);
   assign miss_beat    = rsp_valid && (rsp_status == bst_pkg::STATUS_NOT_FOUND ||
                                       rsp_status == bst_pkg::STATUS_FULL);
   assign miss_clean   = (rsp_node_slot == '0) && (rsp_found_key == '0);

   `BST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // One beat in flight: never ready for a request while a response waits.
   `BST_ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid)

   `BST_ASSERT_NEXT(a_clear_empty, clock, reset, clear_taken, clear_answer)

   // A miss or a full pool names no node.
   `BST_ASSERT_IMPLIES(a_miss_zero, clock, reset, miss_beat, miss_clean)

endmodule

bind binary_search_tree_engine bst_checker #(
   .KEY_BITS  (KEY_BITS),
   .SLOT_BITS (SLOT_BITS)
) u_bst_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_func      (req_chan.func),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_found_key (rsp_chan.found_key),
   .rsp_node_slot (rsp_chan.node_slot),
   .rsp_entries   (rsp_chan.entries)
);

>>> bench/binary_search_tree_engine_tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------------
// Binary search tree engine testbench
// Sends clear, insert, delete, search, ceiling and strict-lower beats and checks every response
// against a tree model kept inside the bench, under random idling on both channels.
// ------------------------------------------------------------------------------------------------
module binary_search_tree_engine_tb;

   localparam int NODES = bst_pkg::NODE_COUNT_DEFAULT;
   localparam int NIL   = NODES;
   localparam int CYCLE_LIMIT = 10000000;

   // Operation codes the engine does not use.
   localparam logic [bst_pkg::FUNC_BITS-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [bst_pkg::FUNC_BITS-1:0] FUNC_SPARE_B = 3'd7;

   typedef struct packed {
      logic [bst_pkg::STATUS_BITS-1:0] status;
      logic signed [31:0]              found_key;
      logic [9:0]                      node_slot;
      logic [10:0]                     entries;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   bst_req_if req_chan ();
   bst_rsp_if rsp_chan ();

   binary_search_tree_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Tree model held in the bench.
   logic signed [31:0] tree_key [NODES];
   int tree_left [NODES];
   int tree_right [NODES];
   int tree_parent [NODES];
   int tree_root = NIL;
   int tree_size = 0;
   int tree_next = 0;
   logic signed [31:0] held_keys [$];

   answer_type answers_due [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   longint cycles = 0;

   function automatic int walk_exact(logic signed [31:0] k);
      int cur;
      cur = tree_root;
      while (cur != NIL) begin
         if (tree_key[cur] == k) return cur;
         cur = (k < tree_key[cur]) ? tree_left[cur] : tree_right[cur];
      end
      return NIL;
   endfunction

   function automatic int walk_bound(logic signed [31:0] k, bit want_ceiling);
      int best;
      int cur;
      best = NIL;
      cur = tree_root;
      while (cur != NIL) begin
         if (want_ceiling ? (k <= tree_key[cur]) : (k > tree_key[cur])) begin
            best = cur;
            cur = want_ceiling ? tree_left[cur] : tree_right[cur];
         end else begin
            cur = want_ceiling ? tree_right[cur] : tree_left[cur];
         end
      end
      return best;
   endfunction

   // Unlinks a node, first removing its successor (or predecessor) and moving it into place.
   function automatic void unlink_node(int id);
      int r;
      int p;
      r = NIL;
      if (tree_right[id] != NIL) begin
         r = tree_right[id];
         while (tree_left[r] != NIL) r = tree_left[r];
      end else if (tree_left[id] != NIL) begin
         r = tree_left[id];
         while (tree_right[r] != NIL) r = tree_right[r];
      end
      if (r != NIL) begin
         unlink_node(r);
         tree_left[r] = tree_left[id];
         tree_right[r] = tree_right[id];
         tree_parent[r] = tree_parent[id];
         if (tree_left[id] != NIL) tree_parent[tree_left[id]] = r;
         if (tree_right[id] != NIL) tree_parent[tree_right[id]] = r;
      end
      p = tree_parent[id];
      if (id == tree_root) begin
         tree_root = r;
      end else if (p != NIL) begin
         if (tree_left[p] == id) tree_left[p] = r;
         else tree_right[p] = r;
      end
   endfunction

   function automatic answer_type tree_apply(logic [bst_pkg::FUNC_BITS-1:0] func,
                                             logic signed [31:0] k);
      answer_type a;
      int slot;
      int cur;
      int par;
      bit go_left;
      a = '0;
      slot = NIL;
      case (func)
         bst_pkg::FUNC_CLEAR: begin
            tree_root = NIL;
            tree_size = 0;
            held_keys.delete();
         end
         bst_pkg::FUNC_INSERT: begin
            if (tree_next >= NODES) begin
               a.status = bst_pkg::STATUS_FULL;
            end else begin
               slot = tree_next;
               tree_key[slot] = k;
               tree_left[slot] = NIL;
               tree_right[slot] = NIL;
               tree_parent[slot] = NIL;
               if (tree_root == NIL) begin
                  tree_root = slot;
               end else begin
                  cur = tree_root;
                  par = tree_root;
                  go_left = 0;
                  while (cur != NIL) begin
                     par = cur;
                     go_left = k < tree_key[cur];
                     cur = go_left ? tree_left[cur] : tree_right[cur];
                  end
                  if (go_left) tree_left[par] = slot;
                  else tree_right[par] = slot;
                  tree_parent[slot] = par;
               end
               tree_next++;
               tree_size++;
               held_keys.push_back(k);
            end
         end
         bst_pkg::FUNC_DELETE: begin
            slot = walk_exact(k);
            if (slot != NIL) begin
               unlink_node(slot);
               if (tree_size > 0) tree_size--;
               foreach (held_keys[i]) if (held_keys[i] == k) begin
                  held_keys.delete(i);
                  break;
               end
            end else begin
               a.status = bst_pkg::STATUS_NOT_FOUND;
            end
         end
         bst_pkg::FUNC_SEARCH, bst_pkg::FUNC_CEIL, bst_pkg::FUNC_LOWER: begin
            slot = (func == bst_pkg::FUNC_SEARCH) ? walk_exact(k)
                                                  : walk_bound(k, func == bst_pkg::FUNC_CEIL);
            if (slot == NIL) a.status = bst_pkg::STATUS_NOT_FOUND;
         end
         default: ;
      endcase
      if (slot != NIL) begin
         a.found_key = tree_key[slot];
         a.node_slot = slot[9:0];
      end
      a.entries = tree_size[10:0];
      return a;
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.func = bst_pkg::FUNC_CLEAR;
      req_chan.key = '0;
      rsp_chan.ready = 1'b0;
   end

   // Sends one beat, idling first at the current rate, and records the expected answer.
   task automatic send_beat(logic [bst_pkg::FUNC_BITS-1:0] func, logic signed [31:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= func;
      req_chan.key <= k;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      answers_due.push_back(tree_apply(func, k));
      beats_sent++;
   endtask

   // Receiver side: random stalls and field-by-field comparison.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (answers_due.size() == 0) begin
               $error("response beat with no request outstanding");
               failures++;
            end else begin
               answer_type e;
               e = answers_due.pop_front();
               beats_checked++;
               if (rsp_chan.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_chan.status);
                  failures++;
               end
               if (rsp_chan.found_key !== e.found_key) begin
                  $error("found_key: expected %0d, got %0d", e.found_key, rsp_chan.found_key);
                  failures++;
               end
               if (rsp_chan.node_slot !== e.node_slot) begin
                  $error("node_slot: expected %0d, got %0d", e.node_slot, rsp_chan.node_slot);
                  failures++;
               end
               if (rsp_chan.entries !== e.entries) begin
                  $error("entries: expected %0d, got %0d", e.entries, rsp_chan.entries);
                  failures++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // A key near one already held, so equal keys and close bounds turn up often.
   function automatic logic signed [31:0] nearby_key();
      logic signed [31:0] k;
      if (held_keys.size() == 0 || $urandom_range(3) == 0) begin
         k = $urandom();
      end else begin
         k = held_keys[$urandom_range(held_keys.size() - 1)];
         k = k + $signed($urandom_range(4)) - 2;
      end
      return k;
   endfunction

   // Extremes of the key, every operation, the empty tree, equal keys and the unused codes.
   task automatic test_directed();
      send_beat(bst_pkg::FUNC_SEARCH, 32'sd5);
      send_beat(bst_pkg::FUNC_CEIL, 32'sd5);
      send_beat(bst_pkg::FUNC_LOWER, 32'sd5);
      send_beat(bst_pkg::FUNC_DELETE, 32'sd5);
      send_beat(bst_pkg::FUNC_INSERT, 32'sd0);
      send_beat(bst_pkg::FUNC_INSERT, 32'h8000_0000);
      send_beat(bst_pkg::FUNC_INSERT, 32'h7fff_ffff);
      send_beat(bst_pkg::FUNC_INSERT, 32'sd0);
      send_beat(bst_pkg::FUNC_INSERT, -32'sd1);
      send_beat(bst_pkg::FUNC_SEARCH, 32'sd0);
      send_beat(bst_pkg::FUNC_CEIL, 32'h8000_0000);
      send_beat(bst_pkg::FUNC_CEIL, 32'sd1);
      send_beat(bst_pkg::FUNC_LOWER, 32'h8000_0000);
      send_beat(bst_pkg::FUNC_LOWER, 32'h7fff_ffff);
      send_beat(FUNC_SPARE_A, 32'sd0);
      send_beat(FUNC_SPARE_B, -32'sd1);
      send_beat(bst_pkg::FUNC_DELETE, 32'sd0);
      send_beat(bst_pkg::FUNC_DELETE, 32'sd0);
      send_beat(bst_pkg::FUNC_DELETE, 32'sd0);
      send_beat(bst_pkg::FUNC_DELETE, 32'h7fff_ffff);
      send_beat(bst_pkg::FUNC_CLEAR, 32'sd0);
      send_beat(bst_pkg::FUNC_SEARCH, -32'sd1);
   endtask

   // Random phase: mostly inserts and lookups on keys close to the held ones.
   task automatic test_random(int count, int ins_weight);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < ins_weight) begin
            send_beat(bst_pkg::FUNC_INSERT, nearby_key());
         end else if (pick < ins_weight + 15) begin
            send_beat(bst_pkg::FUNC_DELETE, nearby_key());
         end else if (pick < 97) begin
            send_beat(bst_pkg::FUNC_SEARCH + 3'($urandom_range(2)), nearby_key());
         end else if (pick < 99) begin
            send_beat(($urandom_range(1) == 0) ? FUNC_SPARE_A : FUNC_SPARE_B, $urandom());
         end else begin
            send_beat(bst_pkg::FUNC_CLEAR, $urandom());
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 23;
      recv_idle_pct = 84;
      test_directed();
      test_random(230, 45);
      send_idle_pct = 84;
      recv_idle_pct = 23;
      test_random(230, 40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(240, 50);
      req_chan.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d request beats and %0d checked responses over all six operations,",
               beats_sent, beats_checked);
      $display("unused codes, empty-tree lookups, equal keys and deletes with replacement chains.");
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
